// ===== design/fifo_multi_unit_resource_pool_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the resource pool checker
// ----------------------------------------------------------------------------
`ifndef FIFO_MULTI_UNIT_RESOURCE_POOL_MACROS_SVH
`define FIFO_MULTI_UNIT_RESOURCE_POOL_MACROS_SVH

// same-cycle implication, disabled in reset
`define FMURP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define FMURP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/fmurp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmurp_pkg
// Shared sizes, codes and control/status types of the resource pool.
// ----------------------------------------------------------------------------
package fmurp_pkg;

    localparam int POOL_SIZE   = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam int ID_W   = 8;
    localparam int TAG_W  = 8;
    localparam int CNT_W  = 5;
    localparam int KIND_W = 2;

    localparam int SIDX_W = $clog2(POOL_SIZE);
    localparam int SCNT_W = $clog2(POOL_SIZE + 1);
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - (TAG_W + ID_W + 1);

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SUBMIT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_GRANT  = 2'd0,
        EV_ZERO   = 2'd1,
        EV_REJECT = 2'd2,
        EV_DROP   = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SERVE,
        ST_GRANT
    } state_t;

    typedef struct packed {
        logic        capture;
        logic        push;
        logic        enqueue;
        logic        load_rem;
        logic        emit;
        event_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_submit;
        logic stack_full;
        logic queue_full;
        logic head_fits;
        logic head_zero;
        logic rem_one;
        logic zero_last;
        logic unit_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/fifo_multi_unit_resource_pool.sv =====
// ----------------------------------------------------------------------------
// fifo_multi_unit_resource_pool
// Counting resource pool: LIFO of free ids, FIFO of requests served in order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                | tuser      | tlast
//  s_      | in  | resource_id, request_tag, count   | command    | -
//  m_      | out | granted_tag, granted_id, complete | event_kind | last result
//
// One transfer at a time: accept, apply, then check the queue head.
// A full queue (reject) or full stack (drop) ends the transfer with its result.
// A served request loads its count at the head check, then gives one grant per unit.
// Results wait in the output register; m_tready low stalls the sequencer.
// Reset clears the stack depth, queue fill and output valid; no clearing pass.
module fifo_multi_unit_resource_pool import fmurp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // resource_id, request_tag, unit_count
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // granted_tag, granted_id, request_complete
    output logic [KIND_W-1:0]    m_tuser,   // event_kind
    output logic                 m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fmurp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmurp_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/fmurp_ram.sv =====
// ----------------------------------------------------------------------------
// fmurp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmurp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fmurp_datapath.sv =====
// ----------------------------------------------------------------------------
// fmurp_datapath
// Free-id stack, shifting request queue, unit counter and result register.
// ----------------------------------------------------------------------------
module fmurp_datapath import fmurp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    // captured input transfer
    logic             in_cmd_reg;
    logic [ID_W-1:0]  in_id_reg;
    logic [TAG_W-1:0] in_tag_reg;
    logic [CNT_W-1:0] in_cnt_reg;

    logic [SCNT_W-1:0] depth_reg, depth_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  rem_reg;

    // queue head always sits at entry 0
    logic [TAG_W-1:0] q_tag_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0] q_cnt_reg [QUEUE_DEPTH];

    logic              m_valid_reg, m_valid_next;
    event_kind_t       m_kind_reg;
    logic [TAG_W-1:0]  m_tag_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic              m_done_reg;
    logic              m_last_reg;

    logic              emit_unit;
    logic              pop_head;
    logic [SCNT_W-1:0] depth_m1;
    logic [SCNT_W-1:0] rd_ptr;
    logic [ID_W-1:0]   top_id;
    logic [CMP_W-1:0]  head_cnt_ext;
    logic [CMP_W-1:0]  next_cnt_ext;
    logic [CMP_W-1:0]  depth_ext;
    logic [CMP_W-1:0]  depth_m1_ext;
    logic              next_valid;
    logic              out_last;

    assign emit_unit = cmd.emit && (cmd.kind == EV_GRANT);
    assign pop_head  = cmd.emit && ((cmd.kind == EV_ZERO) ||
                                    ((cmd.kind == EV_GRANT) && stat.rem_one));
    assign depth_m1  = depth_reg - SCNT_W'(1);

    // read address runs one ahead so the top id is ready when the pop happens
    assign rd_ptr = emit_unit ? (depth_reg - SCNT_W'(2)) : depth_m1;

    fmurp_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_SIZE)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (depth_reg[SIDX_W-1:0]),
        .wr_data (in_id_reg),
        .rd_addr (rd_ptr[SIDX_W-1:0]),
        .rd_data (top_id)
    );

    assign head_cnt_ext = CMP_W'(q_cnt_reg[0]);
    assign next_cnt_ext = CMP_W'(q_cnt_reg[1]);
    assign depth_ext    = CMP_W'(depth_reg);
    assign depth_m1_ext = CMP_W'(depth_m1);
    assign next_valid   = fill_reg >= QCNT_W'(2);

    always_comb begin
        stat.cmd_submit = (in_cmd_reg == CMD_SUBMIT);
        stat.stack_full = (depth_reg == SCNT_W'(POOL_SIZE));
        stat.queue_full = (fill_reg == QCNT_W'(QUEUE_DEPTH));
        stat.head_fits  = (fill_reg != '0) && (head_cnt_ext <= depth_ext);
        stat.head_zero  = (q_cnt_reg[0] == '0);
        stat.rem_one    = (rem_reg == CNT_W'(1));
        // set when the request behind the head would not be served after this result
        stat.zero_last  = !(next_valid && (next_cnt_ext <= depth_ext));
        stat.unit_last  = !(next_valid && (next_cnt_ext <= depth_m1_ext));
        stat.out_free   = !m_valid_reg || m_tready;
    end

    always_comb begin
        case (cmd.kind)
            EV_GRANT: out_last = stat.rem_one && stat.unit_last;
            EV_ZERO:  out_last = stat.zero_last;
            default:  out_last = 1'b1;
        endcase
    end

    always_comb begin
        depth_next = depth_reg;
        if (cmd.push) begin
            depth_next = depth_reg + SCNT_W'(1);
        end else if (emit_unit) begin
            depth_next = depth_m1;
        end
        fill_next = fill_reg;
        if (cmd.enqueue) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop_head) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg <= s_tuser;
            in_id_reg  <= s_tdata[ID_W-1:0];
            in_tag_reg <= s_tdata[ID_W +: TAG_W];
            in_cnt_reg <= s_tdata[ID_W+TAG_W +: CNT_W];
        end
        if (cmd.load_rem) begin
            rem_reg <= q_cnt_reg[0];
        end else if (emit_unit) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
        if (cmd.enqueue) begin
            q_tag_reg[fill_reg[QIDX_W-1:0]] <= in_tag_reg;
            q_cnt_reg[fill_reg[QIDX_W-1:0]] <= in_cnt_reg;
        end else if (pop_head) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                q_tag_reg[i] <= q_tag_reg[i+1];
                q_cnt_reg[i] <= q_cnt_reg[i+1];
            end
        end
        if (cmd.emit) begin
            m_kind_reg <= cmd.kind;
            m_last_reg <= out_last;
            case (cmd.kind)
                EV_GRANT: begin
                    m_tag_reg  <= q_tag_reg[0];
                    m_id_reg   <= top_id;
                    m_done_reg <= stat.rem_one;
                end
                EV_ZERO: begin
                    m_tag_reg  <= q_tag_reg[0];
                    m_id_reg   <= '0;
                    m_done_reg <= 1'b1;
                end
                EV_REJECT: begin
                    m_tag_reg  <= in_tag_reg;
                    m_id_reg   <= '0;
                    m_done_reg <= 1'b1;
                end
                default: begin
                    m_tag_reg  <= '0;
                    m_id_reg   <= in_id_reg;
                    m_done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_done_reg, m_id_reg, m_tag_reg};

endmodule

// ===== design/fmurp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmurp_ctrl
// Sequencer: takes one transfer, applies it and serves the fitting queue heads, or drops/rejects it.
// ----------------------------------------------------------------------------
module fmurp_ctrl import fmurp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.cmd_submit ? stat.queue_full : stat.stack_full) begin
                    if (stat.out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE: begin
                if (!stat.head_fits) begin
                    state_next = ST_IDLE;
                end else if (!stat.head_zero) begin
                    state_next = ST_GRANT;
                end else if (stat.out_free && stat.zero_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_GRANT: begin
                if (stat.out_free && stat.rem_one) begin
                    state_next = stat.unit_last ? ST_IDLE : ST_SERVE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.push     = 1'b0;
        cmd.enqueue  = 1'b0;
        cmd.load_rem = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = EV_GRANT;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                if (stat.cmd_submit) begin
                    cmd.kind = EV_REJECT;
                    if (stat.queue_full) begin
                        cmd.emit = stat.out_free;
                    end else begin
                        cmd.enqueue = 1'b1;
                    end
                end else begin
                    cmd.kind = EV_DROP;
                    if (stat.stack_full) begin
                        cmd.emit = stat.out_free;
                    end else begin
                        cmd.push = 1'b1;
                    end
                end
            end
            ST_SERVE: begin
                cmd.kind = EV_ZERO;
                if (stat.head_fits) begin
                    if (stat.head_zero) begin
                        cmd.emit = stat.out_free;
                    end else begin
                        cmd.load_rem = 1'b1;
                    end
                end
            end
            ST_GRANT: begin
                cmd.kind = EV_GRANT;
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd.kind = EV_GRANT;
            end
        endcase
    end

endmodule

// ===== design/fmurp_checker.sv =====
// ----------------------------------------------------------------------------
// fmurp_checker
// Port-level checks of the resource pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_multi_unit_resource_pool_macros.svh"

module fmurp_checker import fmurp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    `FMURP_ASSERT_NXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `FMURP_ASSERT_NXT(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // one transfer in flight: no accept right after an accept
    `FMURP_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a dropped id is always the only result and never completes a request
    `FMURP_ASSERT_IMP(a_drop_alone, aclk, aresetn, m_tvalid && (m_tuser == EV_DROP), m_tlast && !m_tdata[TAG_W+ID_W])

endmodule

bind fifo_multi_unit_resource_pool fmurp_checker u_fmurp_checker (.*);
